// ----- rtl/circle_from_three_points_top_defines.svh -----
// Assertion macros for the circle-from-three-points block.
`ifndef CIRCLE_FROM_THREE_POINTS_TOP_DEFINES_SVH
`define CIRCLE_FROM_THREE_POINTS_TOP_DEFINES_SVH

// Same-cycle implication.
`define CFP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CFP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cfp_pkg.sv -----
// Shared constants and width helpers for the circle-from-three-points block.
`default_nettype none
package cfp_pkg;

    localparam int COORD_BITS_DEF       = 12;
    localparam int RADIUS_FRAC_BITS_DEF = 4;
    localparam int CENTER_W             = 38;
    localparam int RADIUS_W             = 41;

    localparam logic [63:0] CENTER_MAX     = (64'd1 << (CENTER_W - 1)) - 64'd1;
    localparam logic [63:0] CENTER_NEG_MAG = 64'd1 << (CENTER_W - 1);
    localparam logic [63:0] RADIUS_MAX     = (64'd1 << RADIUS_W) - 64'd1;

    // magnitude bits of ux/uy
    function automatic int uxm_w(input int c);
        return 3 * c + 3;
    endfunction

    // magnitude bits of the center numerators
    function automatic int nxm_w(input int c);
        return 3 * c + 2;
    endfunction

    // magnitude bits of 2*det
    function automatic int denm_w(input int c);
        return 2 * c + 2;
    endfunction

    // root bits; radicand is twice this
    function automatic int sqrt_w(input int c, input int f);
        return 3 * c + 4 + f;
    endfunction

    // {collinear, sign_x, sign_y, |den|, |nx|, |ny|}
    function automatic int side_w(input int c);
        return 3 + denm_w(c) + 2 * nxm_w(c);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/cfp_front.sv -----
// Front pipeline: determinant, numerators, and the squared radius numerator.
`default_nettype none
module cfp_front
    import cfp_pkg::*;
#(
    parameter int COORD_BITS       = COORD_BITS_DEF,
    parameter int RADIUS_FRAC_BITS = RADIUS_FRAC_BITS_DEF,
    localparam int SW  = sqrt_w(COORD_BITS, RADIUS_FRAC_BITS),
    localparam int NW  = 2 * SW,
    localparam int SDW = side_w(COORD_BITS)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [COORD_BITS-1:0] p1_x,
    input  logic [COORD_BITS-1:0] p1_y,
    input  logic [COORD_BITS-1:0] p2_x,
    input  logic [COORD_BITS-1:0] p2_y,
    input  logic [COORD_BITS-1:0] p3_x,
    input  logic [COORD_BITS-1:0] p3_y,
    output logic                  out_valid,
    output logic [NW-1:0]         out_sum,
    output logic [SDW-1:0]        out_side
);

    localparam int C    = COORD_BITS;
    localparam int DW   = C + 1;
    localparam int SQW  = 2 * C;
    localparam int EW   = 2 * C + 2;
    localparam int DETW = 2 * C + 2;
    localparam int PW   = EW + DW;
    localparam int DENW = 2 * C + 3;
    localparam int DXW  = DENW + C + 1;
    localparam int UXM  = uxm_w(C);
    localparam int NXM  = nxm_w(C);
    localparam int DENM = denm_w(C);
    localparam int H    = (UXM + 1) / 2;
    localparam int HB   = UXM - H;
    localparam int SQ2W = 2 * UXM;
    localparam int NSTG = 9;

    logic [NSTG-1:0] vld_reg;

    // stage 1
    logic signed [DW-1:0] a1_reg, b1_reg, c1_reg, d1_reg;
    logic [C-1:0]         x2_1_reg, y2_1_reg;
    logic [SQW-1:0]       q1x_reg, q1y_reg, q2x_reg, q2y_reg, q3x_reg, q3y_reg;
    // stage 2
    logic signed [DW-1:0]   a2_reg, b2_reg, c2_reg, d2_reg;
    logic [C-1:0]           x2_2_reg, y2_2_reg;
    logic signed [DETW-1:0] det2_reg;
    logic signed [EW-1:0]   e1_2_reg, e2_2_reg;
    // stage 3
    logic signed [PW-1:0]   pd1_reg, pb2_reg, pa2_reg, pc1_reg;
    logic signed [DENW-1:0] den3_reg;
    logic                   coll3_reg;
    logic [C-1:0]           x2_3_reg, y2_3_reg;
    // stage 4
    logic signed [PW-1:0]   nx4_reg, ny4_reg;
    logic signed [DXW-1:0]  dx4_reg, dy4_reg;
    logic signed [DENW-1:0] den4_reg;
    logic                   coll4_reg;
    // stage 5
    logic signed [DXW-1:0] ux5_reg, uy5_reg;
    logic [SDW-1:0]        side5_reg;
    // stage 6
    logic [UXM-1:0] uxm6_reg, uym6_reg;
    logic [SDW-1:0] side6_reg;
    // stage 7
    logic [2*H-1:0]    xll7_reg, yll7_reg;
    logic [H+HB-1:0]   xlh7_reg, ylh7_reg;
    logic [2*HB-1:0]   xhh7_reg, yhh7_reg;
    logic [SDW-1:0]    side7_reg;
    // stage 8
    logic [SQ2W-1:0] sqx8_reg, sqy8_reg;
    logic [SDW-1:0]  side8_reg;
    // stage 9
    logic [NW-1:0]  sum9_reg;
    logic [SDW-1:0] side9_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg   <= $signed({1'b0, p1_x}) - $signed({1'b0, p2_x});
            b1_reg   <= $signed({1'b0, p1_y}) - $signed({1'b0, p2_y});
            c1_reg   <= $signed({1'b0, p2_x}) - $signed({1'b0, p3_x});
            d1_reg   <= $signed({1'b0, p2_y}) - $signed({1'b0, p3_y});
            x2_1_reg <= p2_x;
            y2_1_reg <= p2_y;
            q1x_reg  <= p1_x * p1_x;
            q1y_reg  <= p1_y * p1_y;
            q2x_reg  <= p2_x * p2_x;
            q2y_reg  <= p2_y * p2_y;
            q3x_reg  <= p3_x * p3_x;
            q3y_reg  <= p3_y * p3_y;

            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            c2_reg   <= c1_reg;
            d2_reg   <= d1_reg;
            x2_2_reg <= x2_1_reg;
            y2_2_reg <= y2_1_reg;
            det2_reg <= a1_reg * d1_reg - c1_reg * b1_reg;
            e1_2_reg <= $signed({2'b0, q1x_reg}) + $signed({2'b0, q1y_reg})
                      - $signed({2'b0, q2x_reg}) - $signed({2'b0, q2y_reg});
            e2_2_reg <= $signed({2'b0, q2x_reg}) + $signed({2'b0, q2y_reg})
                      - $signed({2'b0, q3x_reg}) - $signed({2'b0, q3y_reg});

            pd1_reg   <= e1_2_reg * d2_reg;
            pb2_reg   <= e2_2_reg * b2_reg;
            pa2_reg   <= e2_2_reg * a2_reg;
            pc1_reg   <= e1_2_reg * c2_reg;
            den3_reg  <= {det2_reg, 1'b0};
            coll3_reg <= (det2_reg == '0);
            x2_3_reg  <= x2_2_reg;
            y2_3_reg  <= y2_2_reg;

            nx4_reg   <= pd1_reg - pb2_reg;
            ny4_reg   <= pa2_reg - pc1_reg;
            dx4_reg   <= den3_reg * $signed({1'b0, x2_3_reg});
            dy4_reg   <= den3_reg * $signed({1'b0, y2_3_reg});
            den4_reg  <= den3_reg;
            coll4_reg <= coll3_reg;

            ux5_reg   <= dx4_reg - DXW'(nx4_reg);
            uy5_reg   <= dy4_reg - DXW'(ny4_reg);
            side5_reg <= {coll4_reg,
                          nx4_reg[PW-1] ^ den4_reg[DENW-1],
                          ny4_reg[PW-1] ^ den4_reg[DENW-1],
                          den4_reg[DENW-1] ? DENM'(-den4_reg) : DENM'(den4_reg),
                          nx4_reg[PW-1] ? NXM'(-nx4_reg) : NXM'(nx4_reg),
                          ny4_reg[PW-1] ? NXM'(-ny4_reg) : NXM'(ny4_reg)};

            uxm6_reg  <= ux5_reg[DXW-1] ? UXM'(-ux5_reg) : UXM'(ux5_reg);
            uym6_reg  <= uy5_reg[DXW-1] ? UXM'(-uy5_reg) : UXM'(uy5_reg);
            side6_reg <= side5_reg;

            // square split in halves to keep each multiplier narrow
            xll7_reg  <= uxm6_reg[H-1:0] * uxm6_reg[H-1:0];
            xlh7_reg  <= uxm6_reg[H-1:0] * uxm6_reg[UXM-1:H];
            xhh7_reg  <= uxm6_reg[UXM-1:H] * uxm6_reg[UXM-1:H];
            yll7_reg  <= uym6_reg[H-1:0] * uym6_reg[H-1:0];
            ylh7_reg  <= uym6_reg[H-1:0] * uym6_reg[UXM-1:H];
            yhh7_reg  <= uym6_reg[UXM-1:H] * uym6_reg[UXM-1:H];
            side7_reg <= side6_reg;

            sqx8_reg  <= (SQ2W'(xhh7_reg) << (2 * H)) + (SQ2W'(xlh7_reg) << (H + 1))
                       + SQ2W'(xll7_reg);
            sqy8_reg  <= (SQ2W'(yhh7_reg) << (2 * H)) + (SQ2W'(ylh7_reg) << (H + 1))
                       + SQ2W'(yll7_reg);
            side8_reg <= side7_reg;

            sum9_reg  <= (NW'(sqx8_reg) + NW'(sqy8_reg)) << (2 * RADIUS_FRAC_BITS);
            side9_reg <= side8_reg;
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_sum   = sum9_reg;
    assign out_side  = side9_reg;

endmodule
`default_nettype wire

// ----- rtl/cfp_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module cfp_sqrt #(
    parameter int SW     = 44,
    parameter int SIDE_W = 1,
    localparam int NW = 2 * SW,
    localparam int RW = SW + 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NW-1:0]     in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [SW-1:0]     out_root,
    output logic [SIDE_W-1:0] out_side
);

    logic [SW:1]       v_reg;
    logic [RW-1:0]     r_reg    [1:SW-1];
    logic [NW-1:0]     n_reg    [1:SW-1];
    logic [SW-1:0]     q_reg    [1:SW];
    logic [SIDE_W-1:0] side_reg [1:SW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[SW-1:1], in_valid};
        end
    end

    for (genvar k = 1; k <= SW; k++) begin : g_stage
        localparam int I = SW - k;
        logic [RW-1:0]     r_prev;
        logic [SW-1:0]     q_prev;
        logic [NW-1:0]     n_prev;
        logic [SIDE_W-1:0] s_prev;
        logic [RW-1:0]     r_sh;
        logic [RW-1:0]     t_val;
        logic              ge;
        logic [RW-1:0]     r_next;
        logic [SW-1:0]     q_next;

        if (k == 1) begin : g_first
            assign r_prev = '0;
            assign q_prev = '0;
            assign n_prev = in_rad;
            assign s_prev = in_side;
        end else begin : g_rest
            assign r_prev = r_reg[k-1];
            assign q_prev = q_reg[k-1];
            assign n_prev = n_reg[k-1];
            assign s_prev = side_reg[k-1];
        end

        assign r_sh   = {r_prev[RW-3:0], n_prev[2*I+1:2*I]};
        assign t_val  = {q_prev, 2'b01};
        assign ge     = (r_sh >= t_val);
        assign r_next = ge ? r_sh - t_val : r_sh;
        assign q_next = {q_prev[SW-2:0], ge};

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k]    <= q_next;
                side_reg[k] <= s_prev;
            end
        end

        if (k < SW) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[k] <= r_next;
                    n_reg[k] <= n_prev;
                end
            end
        end
    end

    assign out_valid = v_reg[SW];
    assign out_root  = q_reg[SW];
    assign out_side  = side_reg[SW];

endmodule
`default_nettype wire

// ----- rtl/cfp_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
`default_nettype none
module cfp_div #(
    parameter int QW     = 44,
    parameter int VW     = 26,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [QW-1:0]     in_dividend,
    input  logic [VW-1:0]     in_divisor,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QW-1:0]     out_quot,
    output logic [SIDE_W-1:0] out_side
);

    logic [QW:1]       v_reg;
    logic [VW-1:0]     rem_reg  [1:QW-1];
    logic [QW-1:0]     d_reg    [1:QW-1];
    logic [VW-1:0]     dv_reg   [1:QW-1];
    logic [QW-1:0]     q_reg    [1:QW];
    logic [SIDE_W-1:0] side_reg [1:QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[QW-1:1], in_valid};
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        localparam int I = QW - k;
        logic [VW-1:0]     rem_prev;
        logic [QW-1:0]     d_prev;
        logic [VW-1:0]     dv_prev;
        logic [QW-1:0]     q_prev;
        logic [SIDE_W-1:0] s_prev;
        logic [VW:0]       rs;
        logic [VW:0]       dv_ext;
        logic              ge;
        logic [VW-1:0]     rem_next;

        if (k == 1) begin : g_first
            assign rem_prev = '0;
            assign d_prev   = in_dividend;
            assign dv_prev  = in_divisor;
            assign q_prev   = '0;
            assign s_prev   = in_side;
        end else begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign d_prev   = d_reg[k-1];
            assign dv_prev  = dv_reg[k-1];
            assign q_prev   = q_reg[k-1];
            assign s_prev   = side_reg[k-1];
        end

        assign rs       = {rem_prev, d_prev[I]};
        assign dv_ext   = {1'b0, dv_prev};
        assign ge       = (rs >= dv_ext);
        assign rem_next = ge ? VW'(rs - dv_ext) : rs[VW-1:0];

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k]    <= {q_prev[QW-2:0], ge};
                side_reg[k] <= s_prev;
            end
        end

        if (k < QW) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= rem_next;
                    d_reg[k]   <= d_prev;
                    dv_reg[k]  <= dv_prev;
                end
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign out_quot  = q_reg[QW];
    assign out_side  = side_reg[QW];

endmodule
`default_nettype wire

// ----- rtl/circle_from_three_points_top.sv -----
// Top level of the circle-from-three-points block.
//
//  channel | ports                                        | dir | handshake
//  --------+----------------------------------------------+-----+-------------------
//  input   | s_p1_x s_p1_y s_p2_x s_p2_y s_p3_x s_p3_y    | in  | s_valid / s_ready
//  result  | m_center_x m_center_y m_radius_q4 m_collinear| out | m_valid / m_ready
//
//  One beat per cycle sustained while m_ready does not stall. The pipeline is 9 front stages,
//  one stage per root bit in the square root, one stage per quotient bit in the dividers,
//  and the output register.
//  Reset is synchronous on aresetn; it clears valid bits only.
//  A stall on m_ready freezes the whole pipeline and drops s_ready in the same cycle.
`default_nettype none
`include "circle_from_three_points_top_defines.svh"
module circle_from_three_points_top
    import cfp_pkg::*;
#(
    parameter int COORD_BITS       = COORD_BITS_DEF,
    parameter int RADIUS_FRAC_BITS = RADIUS_FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_p1_x,
    input  logic [COORD_BITS-1:0] s_p1_y,
    input  logic [COORD_BITS-1:0] s_p2_x,
    input  logic [COORD_BITS-1:0] s_p2_y,
    input  logic [COORD_BITS-1:0] s_p3_x,
    input  logic [COORD_BITS-1:0] s_p3_y,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CENTER_W-1:0]   m_center_x,
    output logic [CENTER_W-1:0]   m_center_y,
    output logic [RADIUS_W-1:0]   m_radius_q4,
    output logic                  m_collinear
);

    localparam int NXM   = nxm_w(COORD_BITS);
    localparam int DENM  = denm_w(COORD_BITS);
    localparam int SW    = sqrt_w(COORD_BITS, RADIUS_FRAC_BITS);
    localparam int SDW   = side_w(COORD_BITS);
    localparam int EXT_W = (SW > RADIUS_W + 1) ? SW : RADIUS_W + 1;

    localparam logic [EXT_W-1:0] CMAX_E = EXT_W'(CENTER_MAX);
    localparam logic [EXT_W-1:0] CNEG_E = EXT_W'(CENTER_NEG_MAG);
    localparam logic [EXT_W-1:0] RMAX_E = EXT_W'(RADIUS_MAX);

    logic               en;
    logic               fr_valid;
    logic [2*SW-1:0]    fr_sum;
    logic [SDW-1:0]     fr_side;
    logic               sq_valid;
    logic [SW-1:0]      sq_root;
    logic [SDW-1:0]     sq_side;
    logic [NXM-1:0]     sq_nxm, sq_nym;
    logic [DENM-1:0]    sq_denm;
    logic               sq_sx, sq_sy, sq_coll;
    logic               rad_valid, cx_valid, cy_valid;
    logic [SW-1:0]      rad_quot, cx_quot, cy_quot;
    logic               rad_coll, cx_neg, cy_neg;
    logic [CENTER_W-1:0] cx_next, cy_next;
    logic [RADIUS_W-1:0] rad_next;

    logic                m_valid_reg;
    logic [CENTER_W-1:0] m_center_x_reg, m_center_y_reg;
    logic [RADIUS_W-1:0] m_radius_q4_reg;
    logic                m_collinear_reg;

    function automatic logic [CENTER_W-1:0] sat_center(input logic [EXT_W-1:0] mag,
                                                        input logic neg);
        logic [CENTER_W-1:0] lo;
        lo = mag[CENTER_W-1:0];
        priority if (!neg && mag > CMAX_E) begin
            return CENTER_W'(CENTER_MAX);
        end else if (neg && mag > CNEG_E) begin
            return CENTER_W'(CENTER_NEG_MAG);
        end else begin
            return neg ? CENTER_W'(~lo + 1'b1) : lo;
        end
    endfunction

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    cfp_front #(
        .COORD_BITS      (COORD_BITS),
        .RADIUS_FRAC_BITS(RADIUS_FRAC_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .p1_x     (s_p1_x),
        .p1_y     (s_p1_y),
        .p2_x     (s_p2_x),
        .p2_y     (s_p2_y),
        .p3_x     (s_p3_x),
        .p3_y     (s_p3_y),
        .out_valid(fr_valid),
        .out_sum  (fr_sum),
        .out_side (fr_side)
    );

    cfp_sqrt #(
        .SW    (SW),
        .SIDE_W(SDW)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (fr_valid),
        .in_rad   (fr_sum),
        .in_side  (fr_side),
        .out_valid(sq_valid),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    assign sq_nym  = sq_side[NXM-1:0];
    assign sq_nxm  = sq_side[2*NXM-1:NXM];
    assign sq_denm = sq_side[2*NXM+DENM-1:2*NXM];
    assign sq_sy   = sq_side[2*NXM+DENM];
    assign sq_sx   = sq_side[2*NXM+DENM+1];
    assign sq_coll = sq_side[2*NXM+DENM+2];

    cfp_div #(
        .QW    (SW),
        .VW    (DENM),
        .SIDE_W(1)
    ) u_div_rad (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (sq_valid),
        .in_dividend(sq_root),
        .in_divisor (sq_denm),
        .in_side    (sq_coll),
        .out_valid  (rad_valid),
        .out_quot   (rad_quot),
        .out_side   (rad_coll)
    );

    cfp_div #(
        .QW    (SW),
        .VW    (DENM),
        .SIDE_W(1)
    ) u_div_cx (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (sq_valid),
        .in_dividend(SW'(sq_nxm)),
        .in_divisor (sq_denm),
        .in_side    (sq_sx),
        .out_valid  (cx_valid),
        .out_quot   (cx_quot),
        .out_side   (cx_neg)
    );

    cfp_div #(
        .QW    (SW),
        .VW    (DENM),
        .SIDE_W(1)
    ) u_div_cy (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (sq_valid),
        .in_dividend(SW'(sq_nym)),
        .in_divisor (sq_denm),
        .in_side    (sq_sy),
        .out_valid  (cy_valid),
        .out_quot   (cy_quot),
        .out_side   (cy_neg)
    );

    always_comb begin
        cx_next  = sat_center(EXT_W'(cx_quot), cx_neg);
        cy_next  = sat_center(EXT_W'(cy_quot), cy_neg);
        rad_next = (EXT_W'(rad_quot) > RMAX_E) ? RADIUS_W'(RADIUS_MAX)
                                               : RADIUS_W'(rad_quot);
        if (rad_coll) begin
            cx_next  = '0;
            cy_next  = '0;
            rad_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= rad_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_center_x_reg  <= cx_next;
            m_center_y_reg  <= cy_next;
            m_radius_q4_reg <= rad_next;
            m_collinear_reg <= rad_coll;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_center_x  = m_center_x_reg;
    assign m_center_y  = m_center_y_reg;
    assign m_radius_q4 = m_radius_q4_reg;
    assign m_collinear = m_collinear_reg;

    `CFP_ASSERT_NOW(a_coll_zero, aclk, aresetn, m_valid && m_collinear,
        m_center_x == '0 && m_center_y == '0 && m_radius_q4 == '0,
        "collinear beat with nonzero fields")
    `CFP_ASSERT_NOW(a_stall_back, aclk, aresetn, m_valid && !m_ready, !s_ready,
        "input taken while output stalled")
    `CFP_ASSERT_NOW(a_div_align, aclk, aresetn, rad_valid || cx_valid || cy_valid,
        rad_valid && cx_valid && cy_valid, "divider lanes out of step")
    `CFP_ASSERT_NEXT(a_front_hold, aclk, aresetn, !s_ready && fr_valid,
        fr_valid && $stable(fr_sum) && $stable(fr_side), "front moved during stall")

endmodule
`default_nettype wire

// ----- bench/tb_circle_from_three_points_top.sv -----
// Testbench for circle_from_three_points_top: directed and random triples, scoreboard check.
`timescale 1ns / 1ps
module tb_circle_from_three_points_top
    import cfp_pkg::*;
();

    localparam int CB = COORD_BITS_DEF;
    localparam int FB = RADIUS_FRAC_BITS_DEF;
    localparam int PIPE_LAT = 10 + 2 * (3 * CB + 4 + FB);
    localparam longint CMAX = (longint'(1) << (CENTER_W - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;
    localparam logic [63:0] RSAT = (64'd1 << RADIUS_W) - 64'd1;

    typedef logic [CB-1:0] coord_t;
    typedef struct packed {
        logic [CENTER_W-1:0] cx;
        logic [CENTER_W-1:0] cy;
        logic [RADIUS_W-1:0] rad;
        logic                coll;
    } circle_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    coord_t s_p1_x = '0, s_p1_y = '0, s_p2_x = '0, s_p2_y = '0, s_p3_x = '0, s_p3_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [CENTER_W-1:0] m_center_x, m_center_y;
    logic [RADIUS_W-1:0] m_radius_q4;
    logic m_collinear;

    circle_t circle_q[$];
    int mismatches = 0;
    int unexpected = 0;
    bit no_idle = 0;
    int hold_cycles = 0;

    circle_from_three_points_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_p1_x(s_p1_x), .s_p1_y(s_p1_y), .s_p2_x(s_p2_x),
        .s_p2_y(s_p2_y), .s_p3_x(s_p3_x), .s_p3_y(s_p3_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_center_x(m_center_x), .m_center_y(m_center_y),
        .m_radius_q4(m_radius_q4), .m_collinear(m_collinear)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [CENTER_W-1:0] clamp_center(input longint v);
        if (v > CMAX) v = CMAX;
        if (v < CMIN) v = CMIN;
        return v[CENTER_W-1:0];
    endfunction

    function automatic circle_t circumcircle(input coord_t p1x, p1y, p2x, p2y, p3x, p3y);
        longint x1, y1, x2, y2, x3, y3, a, b, c, d, det, s2, e1, e2, nx, ny, den, ux, uy;
        logic [63:0] mux, muy, mden, root, rad;
        logic [127:0] sum, cand;
        circle_t r;
        x1 = p1x; y1 = p1y; x2 = p2x; y2 = p2y; x3 = p3x; y3 = p3y;
        a = x1 - x2; b = y1 - y2; c = x2 - x3; d = y2 - y3;
        det = a * d - c * b;
        r = '0;
        if (det == 0) begin
            r.coll = 1'b1;
            return r;
        end
        s2 = x2 * x2 + y2 * y2;
        e1 = x1 * x1 + y1 * y1 - s2;
        e2 = s2 - x3 * x3 - y3 * y3;
        nx = e1 * d - e2 * b;
        ny = e2 * a - e1 * c;
        den = 2 * det;
        ux = den * x2 - nx;
        uy = den * y2 - ny;
        mux = ux < 0 ? -ux : ux;
        muy = uy < 0 ? -uy : uy;
        mden = den < 0 ? -den : den;
        sum = {64'd0, mux} * {64'd0, mux} + {64'd0, muy} * {64'd0, muy};
        sum = sum << (2 * FB);
        root = '0;
        for (int i = 63; i >= 0; i--) begin
            cand = {64'd0, root | (64'd1 << i)};
            if (cand * cand <= sum) root = cand[63:0];
        end
        rad = root / mden;
        if (rad > RSAT) rad = RSAT;
        r.cx = clamp_center(nx / den);
        r.cy = clamp_center(ny / den);
        r.rad = rad[RADIUS_W-1:0];
        return r;
    endfunction

    // prediction on input beats, comparison on result beats
    always @(posedge aclk) begin
        circle_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                circle_q = {circle_q,
                            circumcircle(s_p1_x, s_p1_y, s_p2_x, s_p2_y, s_p3_x, s_p3_y)};
            if (m_valid && m_ready) begin
                if (circle_q.size() == 0) begin
                    unexpected++;
                    if (mismatches + unexpected <= 10)
                        $display("unexpected result beat at %0t", $realtime);
                end else begin
                    want = circle_q.pop_front();
                    if (want.cx !== m_center_x || want.cy !== m_center_y ||
                        want.rad !== m_radius_q4 || want.coll !== m_collinear) begin
                        mismatches++;
                        if (mismatches + unexpected <= 10)
                            $display({"mismatch: exp cx=%0d cy=%0d r=%0d col=%0b",
                                      " got cx=%0d cy=%0d r=%0d col=%0b"},
                                $signed(want.cx), $signed(want.cy), want.rad, want.coll,
                                $signed(m_center_x), $signed(m_center_y), m_radius_q4,
                                m_collinear);
                    end
                end
            end
        end
    end

    // result side: random stalls, optional long hold-off
    initial begin
        int n;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end
            n = no_idle ? 0 : $urandom_range(0, 15);
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(negedge aclk); while (!m_valid);
            @(posedge aclk);
        end
    end

    task automatic send_triple(input coord_t p1x, p1y, p2x, p2y, p3x, p3y);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_p1_x <= p1x; s_p1_y <= p1y; s_p2_x <= p2x;
        s_p2_y <= p2y; s_p3_x <= p3x; s_p3_y <= p3y;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (circle_q.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    function automatic coord_t rnd_coord();
        return coord_t'($urandom);
    endfunction

    task automatic test_directed();
        coord_t mx;
        mx = '1;
        send_triple(0, 0, 0, 0, 0, 0);
        send_triple(mx, mx, mx, mx, mx, mx);
        send_triple(0, 0, mx, 0, 0, mx);
        send_triple(mx, mx, 0, mx, mx, 0);
        send_triple(0, 0, mx, mx, 0, mx);
        send_triple(mx, 0, 0, mx, mx, mx);
        send_triple(0, 0, 1, 1, 2, 2);
        send_triple(0, 0, mx, mx, 100, 100);
        send_triple(10, 10, 10, 10, 500, 7);
        send_triple(0, 0, 1, 0, 0, 1);
        send_triple(0, 0, mx, 1, mx - 1, 1);
        send_triple(0, 0, mx, 0, 2048, 1);
        send_triple(0, 0, 2048, 1, mx, 2);
        send_triple(0, mx, mx, 0, 1, mx - 1);
        send_triple(12'hAAA, 12'h555, 12'h555, 12'hAAA, 12'hFFF, 12'h000);
        send_triple(12'h555, 12'hAAA, 12'hAAA, 12'h555, 12'h000, 12'hFFF);
        send_triple(100, 200, 300, 400, 200, 100);
        send_triple(mx, mx, 0, 0, mx, 0);
        drain();
    endtask

    task automatic random_triple();
        coord_t ax, ay, bx, by, cx, cy;
        int k;
        ax = rnd_coord(); ay = rnd_coord(); bx = rnd_coord(); by = rnd_coord();
        cx = rnd_coord(); cy = rnd_coord();
        case ($urandom_range(0, 9))
            0: begin
                k = $urandom_range(0, 3);
                cx = ax + coord_t'(k * (bx - ax));
                cy = ay + coord_t'(k * (by - ay));
                bx = ax + ((bx - ax) & 12'h00F);
                by = ay + ((by - ay) & 12'h00F);
                cx = ax + coord_t'(k) * (bx - ax);
                cy = ay + coord_t'(k) * (by - ay);
            end
            1: begin bx = ax; by = ay; end
            2: begin
                bx = ax + coord_t'($urandom_range(0, 3));
                by = ay + coord_t'($urandom_range(0, 3));
                cx = ax + coord_t'($urandom_range(0, 3));
                cy = ay + coord_t'($urandom_range(0, 3));
            end
            default: ;
        endcase
        send_triple(ax, ay, bx, by, cx, cy);
    endtask

    task automatic test_random(input int count);
        repeat (count) random_triple();
        drain();
    endtask

    task automatic test_back_to_back(input int count);
        no_idle = 1;
        repeat (count) random_triple();
        drain();
        no_idle = 0;
    endtask

    task automatic test_output_backpressure();
        hold_cycles = 300;
        no_idle = 1;
        repeat (150) random_triple();
        no_idle = 0;
        drain();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(200);
        test_back_to_back(60);
        test_output_backpressure();
        test_random(120);
        while (circle_q.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 20) @(posedge aclk);
        if (mismatches == 0 && unexpected == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cfp_pkg.sv
rtl/cfp_front.sv
rtl/cfp_sqrt.sv
rtl/cfp_div.sv
rtl/circle_from_three_points_top.sv
bench/tb_circle_from_three_points_top.sv
